// ===== design/tevq_pkg.sv =====
// Package for the timer event queue: field widths, kind and result codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package tevq_pkg;

	localparam int TIME_W      = 32;
	localparam int DELAY_W     = 31;
	localparam int ID_W        = 32;
	localparam int KIND_W      = 2;
	localparam int S_DATA_W    = 64;
	localparam int M_DATA_W    = 32;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Input item kinds.
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] RES_ASSIGNED = 2'd0;
	localparam logic [KIND_W-1:0] RES_EXPIRED  = 2'd1;
	localparam logic [KIND_W-1:0] RES_REJECTED = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_CANCEL,
		ST_TICK_SCAN,
		ST_TICK_DECIDE,
		ST_TICK_FINAL
	} state_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_ASSIGNED,
		EMIT_REJECTED,
		EMIT_PENDING
	} emit_t;

	typedef struct packed {
		logic  latch;
		logic  tick_adv;
		logic  addr_clr;
		logic  addr_inc;
		logic  scan_start;
		logic  add_write;
		logic  cancel_mark;
		logic  drop_mark;
		logic  take_best;
		emit_t emit;
		logic  emit_last;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic at_end;
		logic scan_done;
		logic best_found;
		logic out_free;
	} stat_t;

endpackage

// ===== design/tevq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tevq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/tevq_ctrl.sv =====
// Controller state machine of the timer event queue.
// Depends on tevq_pkg; drives the datapath through cmd_t and reads stat_t.
module tevq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [tevq_pkg::KIND_W-1:0] in_kind,
	output logic                       in_ready,
	input  tevq_pkg::stat_t            st,
	output tevq_pkg::cmd_t             cmd
);

	tevq_pkg::state_t state_q, state_d;
	logic [tevq_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic pend_v_q, pend_v_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tevq_pkg::ST_IDLE;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pend_v_d = pend_v_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tevq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (in_kind)
						tevq_pkg::KIND_ADD: begin
							cmd.addr_clr = 1'b1;
							state_d      = tevq_pkg::ST_ADD;
						end
						tevq_pkg::KIND_CANCEL: begin
							cmd.scan_start = 1'b1;
							state_d        = tevq_pkg::ST_CANCEL;
						end
						tevq_pkg::KIND_TICK: begin
							cmd.tick_adv   = 1'b1;
							cmd.scan_start = 1'b1;
							cnt_d          = '0;
							pend_v_d       = 1'b0;
							state_d        = tevq_pkg::ST_TICK_SCAN;
						end
						default: begin
							state_d = tevq_pkg::ST_IDLE;
						end
					endcase
				end
			end
			tevq_pkg::ST_ADD: begin
				if (st.at_end) begin
					if (st.out_free) begin
						cmd.emit = tevq_pkg::EMIT_REJECTED;
						state_d  = tevq_pkg::ST_IDLE;
					end
				end else if (st.slot_free) begin
					if (st.out_free) begin
						cmd.add_write = 1'b1;
						cmd.emit      = tevq_pkg::EMIT_ASSIGNED;
						state_d       = tevq_pkg::ST_IDLE;
					end
				end else begin
					cmd.addr_inc = 1'b1;
				end
			end
			tevq_pkg::ST_CANCEL: begin
				cmd.cancel_mark = 1'b1;
				if (st.scan_done) begin
					state_d = tevq_pkg::ST_IDLE;
				end
			end
			tevq_pkg::ST_TICK_SCAN: begin
				cmd.drop_mark = 1'b1;
				if (st.scan_done) begin
					state_d = tevq_pkg::ST_TICK_DECIDE;
				end
			end
			tevq_pkg::ST_TICK_DECIDE: begin
				if (st.out_free) begin
					if (st.best_found) begin
						cmd.take_best = 1'b1;
						if (pend_v_q) begin
							cmd.emit      = tevq_pkg::EMIT_PENDING;
							cmd.emit_last = 1'b0;
						end
						pend_v_d = 1'b1;
						cnt_d    = cnt_q + tevq_pkg::CNT_W'(1);
						if (cnt_q == tevq_pkg::CNT_W'(tevq_pkg::MAX_RESULTS - 1)) begin
							state_d = tevq_pkg::ST_TICK_FINAL;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = tevq_pkg::ST_TICK_SCAN;
						end
					end else begin
						if (pend_v_q) begin
							cmd.emit      = tevq_pkg::EMIT_PENDING;
							cmd.emit_last = 1'b1;
						end
						pend_v_d = 1'b0;
						state_d  = tevq_pkg::ST_IDLE;
					end
				end
			end
			tevq_pkg::ST_TICK_FINAL: begin
				if (st.out_free) begin
					cmd.emit      = tevq_pkg::EMIT_PENDING;
					cmd.emit_last = 1'b1;
					pend_v_d      = 1'b0;
					state_d       = tevq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tevq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/tevq_datapath.sv =====
// Datapath of the timer event queue: clock and id counters, slot flags, the
// entry RAM, the two-stage scan pipeline with best-candidate registers and the
// output register. Depends on tevq_pkg and tevq_ram.
module tevq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tevq_pkg::cmd_t                   cmd,
	output tevq_pkg::stat_t                  st,
	input  logic [tevq_pkg::S_DATA_W-1:0]    in_data,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [tevq_pkg::M_DATA_W-1:0]    out_data,
	output logic [tevq_pkg::KIND_W-1:0]      out_kind,
	output logic                             out_last
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int RAM_W = tevq_pkg::ID_W + tevq_pkg::TIME_W;
	localparam int TW    = tevq_pkg::TIME_W;
	localparam int DW    = tevq_pkg::DELAY_W;
	localparam int IDW   = tevq_pkg::ID_W;

	logic [TW-1:0]    now_q;
	logic [IDW-1:0]   next_id_q;
	logic [DW-1:0]    delay_q;
	logic [IDW-1:0]   cancel_id_q;
	logic [DEPTH-1:0] valid_q;
	logic [DEPTH-1:0] canc_q;
	logic [CW-1:0]    addr_q;
	logic             run_q;
	logic             done_q;

	logic             v_s1, last_s1;
	logic [IW-1:0]    slot_s1;
	logic             v_s2, last_s2, cand_s2, drop_s2;
	logic [IW-1:0]    slot_s2;
	logic [TW-1:0]    age_s2;
	logic [IDW-1:0]   id_s2;

	logic             best_found_q;
	logic [TW-1:0]    best_age_q;
	logic [IDW-1:0]   best_id_q;
	logic [IW-1:0]    best_slot_q;
	logic [IDW-1:0]   pend_id_q;

	logic                           out_v_q;
	logic [tevq_pkg::KIND_W-1:0]    out_kind_q;
	logic [IDW-1:0]                 out_id_q;
	logic                           out_last_q;

	logic [RAM_W-1:0] wdata, rdata;
	logic [IDW-1:0]   rd_id;
	logic [TW-1:0]    rd_exp, age_s1;
	logic             vbit_s1, cbit_s1, expired_s1;
	logic             better_s2, out_free, addr_last;

	tevq_ram #(
		.WIDTH(RAM_W),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.add_write),
		.waddr(addr_q[IW-1:0]),
		.wdata(wdata),
		.raddr(addr_q[IW-1:0]),
		.rdata(rdata)
	);

	assign wdata      = {next_id_q, now_q + TW'(delay_q)};
	assign rd_id      = rdata[RAM_W-1:TW];
	assign rd_exp     = rdata[TW-1:0];
	assign age_s1     = now_q - rd_exp;
	assign expired_s1 = ~age_s1[TW-1];
	assign vbit_s1    = valid_q[slot_s1];
	assign cbit_s1    = canc_q[slot_s1];
	assign addr_last  = (addr_q == CW'(DEPTH - 1));

	// Strictly better only, so an earlier slot keeps a full tie.
	assign better_s2 = v_s2 && cand_s2 && (!best_found_q || (age_s2 > best_age_q) ||
		((age_s2 == best_age_q) && (id_s2 < best_id_q)));

	assign out_free = !out_v_q || out_ready;

	assign st.slot_free  = !valid_q[addr_q[IW-1:0]];
	assign st.at_end     = (addr_q == CW'(DEPTH));
	assign st.scan_done  = done_q;
	assign st.best_found = best_found_q;
	assign st.out_free   = out_free;

	assign out_valid = out_v_q;
	assign out_data  = out_id_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			next_id_q    <= IDW'(1);
			valid_q      <= '0;
			canc_q       <= '0;
			addr_q       <= '0;
			run_q        <= 1'b0;
			v_s1         <= 1'b0;
			last_s1      <= 1'b0;
			v_s2         <= 1'b0;
			last_s2      <= 1'b0;
			done_q       <= 1'b0;
			best_found_q <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cmd.tick_adv) begin
				now_q <= now_q + TW'(1);
			end

			if (cmd.addr_clr) begin
				addr_q <= '0;
			end else if (cmd.scan_start) begin
				addr_q <= '0;
				run_q  <= 1'b1;
			end else if (cmd.addr_inc || run_q) begin
				addr_q <= addr_q + CW'(1);
				if (run_q && addr_last) begin
					run_q <= 1'b0;
				end
			end

			v_s1    <= run_q;
			last_s1 <= run_q && addr_last;
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			done_q  <= v_s2 && last_s2;

			if (cmd.scan_start) begin
				best_found_q <= 1'b0;
			end else if (better_s2) begin
				best_found_q <= 1'b1;
			end

			if (cmd.cancel_mark && v_s1 && vbit_s1 && (rd_id == cancel_id_q)) begin
				canc_q[slot_s1] <= 1'b1;
			end
			if (cmd.drop_mark && v_s2 && drop_s2) begin
				valid_q[slot_s2] <= 1'b0;
			end
			if (cmd.take_best) begin
				valid_q[best_slot_q] <= 1'b0;
			end
			if (cmd.add_write) begin
				valid_q[addr_q[IW-1:0]] <= 1'b1;
				canc_q[addr_q[IW-1:0]]  <= 1'b0;
				next_id_q               <= next_id_q + IDW'(1);
			end

			if (cmd.emit != tevq_pkg::EMIT_NONE) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			delay_q     <= in_data[DW-1:0];
			cancel_id_q <= in_data[DW+IDW-1:DW];
		end

		slot_s1 <= addr_q[IW-1:0];
		slot_s2 <= slot_s1;
		age_s2  <= age_s1;
		id_s2   <= rd_id;
		cand_s2 <= vbit_s1 && !cbit_s1 && expired_s1;
		drop_s2 <= vbit_s1 && cbit_s1 && expired_s1;

		if (better_s2) begin
			best_age_q  <= age_s2;
			best_id_q   <= id_s2;
			best_slot_q <= slot_s2;
		end
		if (cmd.take_best) begin
			pend_id_q <= best_id_q;
		end

		case (cmd.emit)
			tevq_pkg::EMIT_ASSIGNED: begin
				out_kind_q <= tevq_pkg::RES_ASSIGNED;
				out_id_q   <= next_id_q;
				out_last_q <= 1'b1;
			end
			tevq_pkg::EMIT_REJECTED: begin
				out_kind_q <= tevq_pkg::RES_REJECTED;
				out_id_q   <= '0;
				out_last_q <= 1'b1;
			end
			tevq_pkg::EMIT_PENDING: begin
				out_kind_q <= tevq_pkg::RES_EXPIRED;
				out_id_q   <= pend_id_q;
				out_last_q <= cmd.emit_last;
			end
			default: begin
				out_kind_q <= out_kind_q;
			end
		endcase
	end

endmodule

// ===== design/timer_event_queue_with_cancel.sv =====
// Top level of the timer event queue with cancel.
// Depends on tevq_pkg, tevq_ctrl, tevq_datapath (which holds tevq_ram).
//
// The block keeps up to QUEUE_DEPTH one-shot timer events, each stored as an
// expiry time and a 32-bit id in one entry RAM, with a valid and a cancelled
// flag per slot in flip-flops. One input transaction is processed at a time.
// An add searches the slot flags from the lowest slot up, one slot per cycle;
// it writes expiry = now + delay and returns the new id, or a rejected result
// with id zero when the table is full. A cancel reads every entry through the
// RAM read port, flags each valid entry whose id matches and returns nothing.
// A tick advances the millisecond counter, then runs one full scan of the RAM
// per reported event, plus a last scan that finds none when fewer than 16 are
// reported, keeping the earliest expiry (lower id, then lower slot, on ties).
// Adds and ticks also wait while the output register is still occupied.
// Cancelled events that have expired are dropped silently during the scans.
// The single RAM read port makes each scan visit the slots one at a time.
// Every result is held in an output register, so the block takes the next
// input transaction while a finished result still waits on m_tready. The
// last result caused by an input transaction carries m_tlast. Time
// comparisons wrap modulo 2^32, id comparisons are plain unsigned, and the
// id after 2^32-1 is 0.
module timer_event_queue_with_cancel #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // delay_ms [30:0], cancel_id [62:31], zero [63]
	input  logic [1:0]  s_tuser,   // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // event_id [31:0]
	output logic [1:0]  m_tuser,   // result_kind [1:0]
	output logic        m_tlast
);

	tevq_pkg::cmd_t  cmd;
	tevq_pkg::stat_t st;

	tevq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_kind (s_tuser),
		.in_ready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	tevq_datapath #(
		.DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_data  (s_tdata),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (m_tdata),
		.out_kind (m_tuser),
		.out_last (m_tlast)
	);

endmodule

// ===== design/tevq_checker.sv =====
// Port-level checker for the timer event queue, bound to the top level.
// Depends on tevq_pkg.
module tevq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result keeps its content.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
	else $error("stalled result changed");

	// A rejected add reports id zero as the only result.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tevq_pkg::RES_REJECTED) |-> (m_tdata == 32'd0) && m_tlast)
	else $error("rejected result malformed");

	// An assigned id is always the single result of its add.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tevq_pkg::RES_ASSIGNED) |-> m_tlast)
	else $error("assigned result without last");

	// An accepted add keeps the input side closed for the slot search.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == tevq_pkg::KIND_ADD) |=> !s_tready)
	else $error("input accepted during add");

endmodule

bind timer_event_queue_with_cancel tevq_checker u_tevq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// ===== dv/timer_event_queue_with_cancel_tb.sv =====
// Testbench for timer_event_queue_with_cancel: a directed table, then random
// add/cancel/tick sequences; results checked against typed rows or an in-bench timer model.
// Depends on tevq_pkg and the timer_event_queue_with_cancel RTL.
module timer_event_queue_with_cancel_tb;

	localparam int QUEUE_DEPTH = 16;
	localparam int KW = tevq_pkg::KIND_W;
	localparam int DW = tevq_pkg::DELAY_W;
	localparam int IW = tevq_pkg::ID_W;
	localparam int TW = tevq_pkg::TIME_W;
	localparam logic [KW-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 305;
	localparam int PHASE_LEN = 102;
	// The receiver hold-off starts once this many transactions went in.
	localparam int HOLD_AT = 280;
	localparam int HOLD_CYCLES = 400;
	// A tick that reports sixteen events needs sixteen scans.
	localparam int SETTLE_CYCLES = 600;
	localparam int DRAIN_LIMIT = 50000;
	localparam int LARGE_DELAY_BUDGET = 2;

	typedef struct packed {
		logic [KW-1:0] kind;
		logic [DW-1:0] delay;
		logic [IW-1:0] cid;
	} timer_item_t;

	typedef struct packed {
		logic [KW-1:0] kind;
		logic [IW-1:0] id;
		logic          last;
	} timer_result_t;

	// A directed row either carries its expected result typed in, or is
	// left to the timer model.
	typedef struct packed {
		timer_item_t   stim;
		logic          typed;
		logic          emits;
		timer_result_t res;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	timer_event_queue_with_cancel #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Timer model state.
	logic [TW-1:0] tm_now;
	logic [IW-1:0] tm_next_id;
	logic [TW-1:0] tm_expiry [QUEUE_DEPTH];
	logic [IW-1:0] tm_id [QUEUE_DEPTH];
	logic          tm_valid [QUEUE_DEPTH];
	logic          tm_cancelled [QUEUE_DEPTH];

	timer_result_t step_results [$];
	timer_result_t awaited_results [$];
	timer_item_t   upcoming_items [$];
	directed_row_t directed_rows [$];

	int error_count = 0;
	int accepted_count = 0;
	int idle_phase = 0;
	int large_left = LARGE_DELAY_BUDGET;
	timer_result_t want;

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic timer_item_t make_item(input logic [KW-1:0] kind,
			input logic [DW-1:0] delay, input logic [IW-1:0] cid);
		timer_item_t it;
		it.kind = kind;
		it.delay = delay;
		it.cid = cid;
		return it;
	endfunction

	function automatic timer_result_t make_result(input logic [KW-1:0] kind,
			input logic [IW-1:0] id, input logic last);
		timer_result_t r;
		r.kind = kind;
		r.id = id;
		r.last = last;
		return r;
	endfunction

	// How long ago an entry expired; bit 31 clear means it has expired.
	function automatic logic [TW-1:0] age_of(input int s);
		return tm_now - tm_expiry[s];
	endfunction

	function automatic bit has_expired(input int s);
		logic [TW-1:0] a;
		a = age_of(s);
		return !a[TW-1];
	endfunction

	// Earliest expiry leaves first, then the lower id, then the lower slot.
	function automatic bit leaves_first(input int a, input int b);
		if (age_of(a) != age_of(b)) return age_of(a) > age_of(b);
		if (tm_id[a] != tm_id[b]) return tm_id[a] < tm_id[b];
		return a < b;
	endfunction

	// Applies one accepted transaction to the timer model and leaves the
	// results it causes in step_results.
	task automatic apply_to_timer_model(input timer_item_t it);
		int i;
		int best;
		int n;
		bit placed;
		timer_result_t r;
		step_results.delete();
		case (it.kind)
			tevq_pkg::KIND_ADD: begin
				placed = 1'b0;
				for (i = 0; i < QUEUE_DEPTH; i++) begin
					if (!placed && !tm_valid[i]) begin
						tm_valid[i] = 1'b1;
						tm_cancelled[i] = 1'b0;
						tm_expiry[i] = tm_now + {1'b0, it.delay};
						tm_id[i] = tm_next_id;
						tm_next_id = tm_next_id + IW'(1);
						step_results.push_back(make_result(tevq_pkg::RES_ASSIGNED,
							tm_id[i], 1'b1));
						placed = 1'b1;
					end
				end
				if (!placed) begin
					step_results.push_back(make_result(tevq_pkg::RES_REJECTED, '0, 1'b1));
				end
			end
			tevq_pkg::KIND_CANCEL: begin
				for (i = 0; i < QUEUE_DEPTH; i++) begin
					if (tm_valid[i] && tm_id[i] == it.cid) tm_cancelled[i] = 1'b1;
				end
			end
			tevq_pkg::KIND_TICK: begin
				tm_now = tm_now + TW'(1);
				// Expired cancelled events vanish without a result.
				for (i = 0; i < QUEUE_DEPTH; i++) begin
					if (tm_valid[i] && tm_cancelled[i] && has_expired(i)) tm_valid[i] = 1'b0;
				end
				n = 0;
				best = 0;
				while (n < tevq_pkg::MAX_RESULTS && best >= 0) begin
					best = -1;
					for (i = 0; i < QUEUE_DEPTH; i++) begin
						if (tm_valid[i] && has_expired(i)) begin
							if (best < 0 || leaves_first(i, best)) best = i;
						end
					end
					if (best >= 0) begin
						tm_valid[best] = 1'b0;
						step_results.push_back(make_result(tevq_pkg::RES_EXPIRED,
							tm_id[best], 1'b0));
						n++;
					end
				end
				if (n > 0) begin
					r = step_results.pop_back();
					r.last = 1'b1;
					step_results.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic int sender_idle_pct();
		case (idle_phase)
			0: return 38;
			1: return 48;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (idle_phase)
			0: return 48;
			1: return 38;
			default: return 0;
		endcase
	endfunction

	// Mostly short delays so events expire within the run; a few huge ones
	// that stay in the table for good, so their number is capped.
	function automatic logic [DW-1:0] pick_delay();
		int r;
		logic [31:0] raw;
		r = $urandom_range(0, 99);
		raw = $urandom();
		if (r < 85) return DW'($urandom_range(0, 10));
		if (r < 97) return DW'($urandom_range(11, 60));
		if (large_left > 0) begin
			large_left--;
			return {1'b1, raw[DW-2:0]};
		end
		return DW'($urandom_range(0, 10));
	endfunction

	// Queues the next random sequence. Most are well formed: some adds, a few
	// cancels aimed at live or just-added ids, then ticks. Now and then a long
	// burst of adds overruns the table, and the rest is noise.
	task automatic plan_sequence();
		int r;
		int n;
		int j;
		logic [IW-1:0] ids [$];
		timer_item_t it;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			for (j = 0; j < QUEUE_DEPTH + 1; j++) begin
				upcoming_items.push_back(make_item(tevq_pkg::KIND_ADD,
					DW'($urandom_range(1, 8)), $urandom()));
			end
		end else if (r < 75) begin
			for (j = 0; j < QUEUE_DEPTH; j++) begin
				if (tm_valid[j] && !tm_cancelled[j]) ids.push_back(tm_id[j]);
			end
			n = $urandom_range(1, 5);
			for (j = 0; j < n; j++) begin
				upcoming_items.push_back(make_item(tevq_pkg::KIND_ADD, pick_delay(),
					$urandom()));
				ids.push_back(tm_next_id + IW'(j));
			end
			n = $urandom_range(0, 2);
			for (j = 0; j < n; j++) begin
				upcoming_items.push_back(make_item(tevq_pkg::KIND_CANCEL, DW'($urandom()),
					ids[$urandom_range(0, ids.size() - 1)]));
			end
			n = $urandom_range(1, 6);
			for (j = 0; j < n; j++) begin
				upcoming_items.push_back(make_item(tevq_pkg::KIND_TICK, DW'($urandom()),
					$urandom()));
			end
		end else begin
			n = $urandom_range(1, 3);
			for (j = 0; j < n; j++) begin
				it = make_item(KW'($urandom_range(0, 3)), DW'($urandom()), $urandom());
				if (it.kind == tevq_pkg::KIND_ADD && it.delay > DW'(60)) begin
					if (large_left > 0) large_left--;
					else it.delay = DW'(it.delay % 61);
				end
				upcoming_items.push_back(it);
			end
		end
	endtask

	function automatic void add_row(input timer_item_t stim, input logic typed,
			input logic emits, input timer_result_t res);
		directed_row_t row;
		row.stim = stim;
		row.typed = typed;
		row.emits = emits;
		row.res = res;
		directed_rows.push_back(row);
	endfunction

	// Offers one transaction, holds it until accepted, then runs the model.
	task automatic send_item(input timer_item_t it);
		while ($urandom_range(0, 99) < sender_idle_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {1'b0, it.cid, it.delay};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_to_timer_model(it);
		accepted_count++;
	endtask

	task automatic await_model_results();
		while (step_results.size() != 0) awaited_results.push_back(step_results.pop_front());
	endtask

	function automatic void build_directed_table();
		timer_result_t none;
		int j;
		none = make_result(tevq_pkg::RES_ASSIGNED, '0, 1'b0);
		// A tick on an empty table reports nothing.
		add_row(make_item(tevq_pkg::KIND_TICK, '0, '0), 1'b1, 1'b0, none);
		// Longest delay: this event never expires during the run.
		add_row(make_item(tevq_pkg::KIND_ADD, 31'h7FFF_FFFF, '0), 1'b1, 1'b1,
			make_result(tevq_pkg::RES_ASSIGNED, 32'd1, 1'b1));
		// Zero delay expires on the next tick.
		add_row(make_item(tevq_pkg::KIND_ADD, '0, 32'hFFFF_FFFF), 1'b1, 1'b1,
			make_result(tevq_pkg::RES_ASSIGNED, 32'd2, 1'b1));
		// Cancels that match no id are ignored.
		add_row(make_item(tevq_pkg::KIND_CANCEL, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b1, 1'b0,
			none);
		add_row(make_item(tevq_pkg::KIND_CANCEL, '0, '0), 1'b1, 1'b0, none);
		// The unused kind is ignored.
		add_row(make_item(KIND_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b1, 1'b0, none);
		add_row(make_item(tevq_pkg::KIND_TICK, '0, '0), 1'b1, 1'b1,
			make_result(tevq_pkg::RES_EXPIRED, 32'd2, 1'b1));
		add_row(make_item(tevq_pkg::KIND_ADD, 31'd1, '0), 1'b1, 1'b1,
			make_result(tevq_pkg::RES_ASSIGNED, 32'd3, 1'b1));
		add_row(make_item(tevq_pkg::KIND_ADD, 31'd1, '0), 1'b0, 1'b0, none);
		// Cancel an event that shares its expiry with a live one.
		add_row(make_item(tevq_pkg::KIND_CANCEL, '0, 32'd4), 1'b0, 1'b0, none);
		// Fill the table with equal and staggered expiries.
		for (j = 0; j < QUEUE_DEPTH - 3; j++) begin
			add_row(make_item(tevq_pkg::KIND_ADD, DW'(3 + (j % 3)), '0), 1'b0, 1'b0, none);
		end
		// Table full.
		add_row(make_item(tevq_pkg::KIND_ADD, 31'd2, '0), 1'b1, 1'b1,
			make_result(tevq_pkg::RES_REJECTED, '0, 1'b1));
		add_row(make_item(tevq_pkg::KIND_TICK, '0, '0), 1'b0, 1'b0, none);
	endfunction

	// Result checker: every result transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d id %0h last %0b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = awaited_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("result_kind %0d, wanted %0d", m_tuser, want.kind));
				if (m_tdata !== want.id)
					report_mismatch($sformatf("event_id %0h, wanted %0h", m_tdata, want.id));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %0b, wanted %0b", m_tlast, want.last));
			end
		end
	end

	// Receiver: random back-pressure by phase, plus one long hold-off that
	// lets the block fill up and stall its input.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && accepted_count >= HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
			end
		end
	end

	// Stimulus and end of test.
	initial begin
		int random_items;
		int waited;
		timer_item_t it;
		tm_now = '0;
		tm_next_id = 32'd1;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			tm_expiry[i] = '0;
			tm_id[i] = '0;
			tm_valid[i] = 1'b0;
			tm_cancelled[i] = 1'b0;
		end
		build_directed_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].stim);
			if (directed_rows[k].typed) begin
				step_results.delete();
				if (directed_rows[k].emits) awaited_results.push_back(directed_rows[k].res);
			end else begin
				await_model_results();
			end
		end

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			idle_phase = (random_items < PHASE_LEN) ? 0 :
				(random_items < 2 * PHASE_LEN) ? 1 : 2;
			if (upcoming_items.size() == 0) plan_sequence();
			it = upcoming_items.pop_front();
			send_item(it);
			await_model_results();
			if (it.kind != KIND_UNUSED) random_items++;
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				awaited_results.size()));

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
